### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the positional list store.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PLST_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("plst assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define PLST_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plst assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define PLST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plst assertion failed");

`endif

### rtl/plst_pkg.sv
// Shared types and constants for the positional list store.
// No dependencies; imported by the cell, the controller and the top level.
package plst_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = 7;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int KIND_W   = 3;

  typedef enum logic [KIND_W-1:0] {
    K_INS_FRONT = 3'd0,
    K_INS_POS   = 3'd1,
    K_INS_END   = 3'd2,
    K_REM_FRONT = 3'd3,
    K_REM_POS   = 3'd4,
    K_REM_END   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    op_t                      op;
    logic [IDX_W-1:0]         at;
    logic signed [DATA_W-1:0] value;
  } plst_cmd_t;

endpackage

### rtl/positional_list_store_core.sv
// Top level of the positional list store: controller, chain of cells and
// result register. Depends on plst_pkg, plst_ctrl and plst_cell.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------------
//  request | req_valid | req_stall | kind, position, value
//  result  | rsp_valid | rsp_stall | removed_value, status, fill_count
//
// One request per cycle while req_stall is low: the cells from the target on shift
// in the same cycle as the transfer, and the result appears in the result register on the next cycle.
// Reset clears the count and the result valid; element contents stay as they
// are and are never read before they are written.
// A stalled result holds the request channel in stall until it is taken.
module positional_list_store_core
  import plst_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic [KIND_W-1:0]        kind,
  input  logic [CNT_W-1:0]         position,
  input  logic signed [DATA_W-1:0] value,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic signed [DATA_W-1:0] removed_value,
  output logic [1:0]               status,
  output logic [CNT_W-1:0]         fill_count
);

  logic                     fire;
  plst_cmd_t                cmd;
  status_t                  req_status;
  logic [CNT_W-1:0]         count_next;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic signed [DATA_W-1:0] cell_pick [CAPACITY];
  logic signed [DATA_W-1:0] picked;

  assign req_stall = rsp_valid && rsp_stall;
  assign fire      = req_valid && !req_stall;

  plst_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .kind       (kind),
    .position   (position),
    .value      (value),
    .cmd        (cmd),
    .status     (req_status),
    .count_next (count_next)
  );

  // Build the chain; the first cell sees a zero on the left and the last cell itself on the right
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_in;
    logic signed [DATA_W-1:0] right_in;

    if (g == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_in = cell_data[g];
    end else begin : g_mid_r
      assign right_in = cell_data[g+1];
    end

    plst_cell u_cell (
      .clk        (clk),
      .fire       (fire),
      .cmd        (cmd),
      .idx        (IDX_W'(g)),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[g]),
      .pick       (cell_pick[g])
    );
  end

  // Gather the offered element of the target cell
  always_comb begin
    picked = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      picked = picked | cell_pick[i];
    end
  end

  // Load the result register on each request transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      removed_value <= (cmd.op == OP_REMOVE) ? picked : '0;
      status        <= req_status;
      fill_count    <= count_next;
    end
  end

endmodule

### rtl/plst_cell.sv
// One storage cell of the chain: holds a single element and shifts it
// to or from its neighbours. Depends on plst_pkg.
module plst_cell
  import plst_pkg::*;
(
  input  logic                     clk,
  input  logic                     fire,
  input  plst_cmd_t                cmd,
  input  logic [IDX_W-1:0]         idx,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0] data,
  output logic signed [DATA_W-1:0] pick
);

  // Offer the held element when this cell is the target
  assign pick = (idx == cmd.at) ? data : '0;

  // Take the new value, shift back on insert, shift forward on remove
  always_ff @(posedge clk) begin
    if (fire) begin
      case (cmd.op)
        OP_INSERT: begin
          if (idx == cmd.at) begin
            data <= cmd.value;
          end else if (idx > cmd.at) begin
            data <= left_data;
          end
        end
        OP_REMOVE: begin
          if (idx >= cmd.at) begin
            data <= right_data;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/plst_ctrl.sv
// Request decoder and element count for the positional list store.
// Depends on plst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module plst_ctrl
  import plst_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  logic [KIND_W-1:0]        kind,
  input  logic [CNT_W-1:0]         position,
  input  logic signed [DATA_W-1:0] value,
  output plst_cmd_t                cmd,
  output status_t                  status,
  output logic [CNT_W-1:0]         count_next
);

  logic [CNT_W-1:0] count;
  logic             full;
  logic             empty;
  logic             pos_ok;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] last_idx;

  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign pos_ok   = (position != '0) && (position <= count);
  assign pos_idx  = IDX_W'(position - CNT_W'(1));
  assign last_idx = IDX_W'(count - CNT_W'(1));

  // Decode the request against the current count
  always_comb begin
    cmd.op    = OP_HOLD;
    cmd.at    = '0;
    cmd.value = value;
    status    = ST_OK;
    case (kind_t'(kind))
      K_INS_FRONT: begin
        if (full) status = ST_FULL;
        else cmd.op = OP_INSERT;
      end
      K_INS_POS: begin
        if (full) begin
          status = ST_FULL;
        end else if (!pos_ok) begin
          status = ST_BADPOS;
        end else begin
          cmd.op = OP_INSERT;
          cmd.at = pos_idx;
        end
      end
      K_INS_END: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.op = OP_INSERT;
          cmd.at = IDX_W'(count);
        end
      end
      K_REM_FRONT: begin
        if (empty) status = ST_EMPTY;
        else cmd.op = OP_REMOVE;
      end
      K_REM_POS: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (!pos_ok) begin
          status = ST_BADPOS;
        end else begin
          cmd.op = OP_REMOVE;
          cmd.at = pos_idx;
        end
      end
      K_REM_END: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cmd.op = OP_REMOVE;
          cmd.at = last_idx;
        end
      end
      default: begin
      end
    endcase
  end

  // Grow or shrink the count with the operation
  always_comb begin
    case (cmd.op)
      OP_INSERT: count_next = count + CNT_W'(1);
      OP_REMOVE: count_next = count - CNT_W'(1);
      default:   count_next = count;
    endcase
  end

  // Hold the count between transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  `PLST_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(CAPACITY))
  `PLST_ASSERT_IMPL(a_reject_holds, clk, rst, status != ST_OK, cmd.op == OP_HOLD)
  `PLST_ASSERT_NEXT(a_insert_grows, clk, rst, fire && cmd.op == OP_INSERT, count == CNT_W'($past(count) + CNT_W'(1)))

endmodule
